// ===== design/user_table_ring_lookup_assert.svh =====
// Assertion macros for the user table ring lookup design file.
`ifndef USER_TABLE_RING_LOOKUP_ASSERT_SVH
`define USER_TABLE_RING_LOOKUP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define UTRL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define UTRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/utrl_pkg.sv =====
// Shared types and constants of the user table ring lookup block.
package utrl_pkg;

   localparam int KEY_W      = 64;
   localparam int UID_W      = 32;
   localparam int PRIV_W     = 8;
   localparam int CMD_W      = 3;
   localparam int TSEL_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_DATA_W = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP_NAME = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP_UID  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_RETRIEVED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DELETED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TABLE = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CMD   = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

   // per-table ring control
   typedef struct packed {
      logic shift;
      logic clear_head;
      logic load;
   } ring_ctrl_type;

endpackage

// ===== design/utrl_cell.sv =====
// One ring cell: holds a single user entry and passes it on when the ring shifts.
module utrl_cell
   import utrl_pkg::*;
#(
   parameter int NAME_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic                 load,
   input  logic [NAME_BITS-1:0] sh_name,
   input  logic [PRIV_W-1:0]    sh_priv,
   input  logic [UID_W-1:0]     sh_uid,
   input  logic [NAME_BITS-1:0] ld_name,
   input  logic [PRIV_W-1:0]    ld_priv,
   input  logic [UID_W-1:0]     ld_uid,
   output logic [NAME_BITS-1:0] cur_name,
   output logic [PRIV_W-1:0]    cur_priv,
   output logic [UID_W-1:0]     cur_uid
);

   logic [NAME_BITS-1:0] name_ff, name_in;
   logic [PRIV_W-1:0]    priv_ff, priv_in;
   logic [UID_W-1:0]     uid_ff, uid_in;

   // take a new entry on insert, else the neighbor's entry on shift, else hold
   always_comb begin
      name_in = name_ff;
      priv_in = priv_ff;
      uid_in  = uid_ff;
      if (load) begin
         name_in = ld_name;
         priv_in = ld_priv;
         uid_in  = ld_uid;
      end else if (shift) begin
         name_in = sh_name;
         priv_in = sh_priv;
         uid_in  = sh_uid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff <= '0;
         priv_ff <= '0;
         uid_ff  <= '0;
      end else begin
         name_ff <= name_in;
         priv_ff <= priv_in;
         uid_ff  <= uid_in;
      end
   end

   assign cur_name = name_ff;
   assign cur_priv = priv_ff;
   assign cur_uid  = uid_ff;

endmodule

// ===== design/utrl_ring.sv =====
// One user table: a ring of entry cells that rotates one slot per cycle past its head while shift is set.
module utrl_ring
   import utrl_pkg::*;
#(
   parameter int ENTRIES   = 16,
   parameter int NAME_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ring_ctrl_type              ctrl,
   input  logic [$clog2(ENTRIES)-1:0] load_idx,
   input  logic [NAME_BITS-1:0]       ld_name,
   input  logic [PRIV_W-1:0]          ld_priv,
   input  logic [UID_W-1:0]           ld_uid,
   output logic [NAME_BITS-1:0]       head_name,
   output logic [PRIV_W-1:0]          head_priv,
   output logic [UID_W-1:0]           head_uid
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic [NAME_BITS-1:0] cell_name [ENTRIES];
   logic [PRIV_W-1:0]    cell_priv [ENTRIES];
   logic [UID_W-1:0]     cell_uid  [ENTRIES];
   logic [NAME_BITS-1:0] tail_name;
   logic [PRIV_W-1:0]    tail_priv;
   logic [UID_W-1:0]     tail_uid;

   // drop the head entry on its way to the tail when it is cleared
   always_comb begin
      tail_name = ctrl.clear_head ? '0 : cell_name[0];
      tail_priv = ctrl.clear_head ? '0 : cell_priv[0];
      tail_uid  = ctrl.clear_head ? '0 : cell_uid[0];
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [NAME_BITS-1:0] nb_name;
      logic [PRIV_W-1:0]    nb_priv;
      logic [UID_W-1:0]     nb_uid;

      if (i == ENTRIES - 1) begin : g_tail
         assign nb_name = tail_name;
         assign nb_priv = tail_priv;
         assign nb_uid  = tail_uid;
      end else begin : g_mid
         assign nb_name = cell_name[i+1];
         assign nb_priv = cell_priv[i+1];
         assign nb_uid  = cell_uid[i+1];
      end

      utrl_cell #(
         .NAME_BITS(NAME_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (ctrl.shift),
         .load    (ctrl.load && (load_idx == IDX_W'(i))),
         .sh_name (nb_name),
         .sh_priv (nb_priv),
         .sh_uid  (nb_uid),
         .ld_name (ld_name),
         .ld_priv (ld_priv),
         .ld_uid  (ld_uid),
         .cur_name(cell_name[i]),
         .cur_priv(cell_priv[i]),
         .cur_uid (cell_uid[i])
      );
   end

   assign head_name = cell_name[0];
   assign head_priv = cell_priv[0];
   assign head_uid  = cell_uid[0];

endmodule

// ===== design/user_table_ring_lookup.sv =====
// Flow: an accepted item is latched, then swept while the table rings rotate one slot per
// cycle past their head compare, then answered from the result register; a bad table or
// command skips the sweep. A new item is taken only in idle, after the last one is answered.
// Reset: synchronous, active high; clears every entry, write pointer and uid allocator
// directly, with no clearing pass.
`include "user_table_ring_lookup_assert.svh"

module user_table_ring_lookup
   import utrl_pkg::*;
#(
   parameter int ENTRIES   = 16,
   parameter int TABLES    = 3,
   parameter int NAME_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CMD_W-1:0]              req_cmd,
   input  logic [TSEL_W-1:0]             req_table_sel,
   input  logic [KEY_W-1:0]              req_name_key,
   input  logic [PRIV_W-1:0]             req_priv,
   input  logic [UID_W-1:0]              req_uid,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic [TSEL_W-1:0]             rsp_table_out,
   output logic [KEY_W-1:0]              rsp_found_name,
   output logic [PRIV_W-1:0]             rsp_found_priv,
   output logic [UID_W-1:0]              rsp_found_uid,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [$clog2(2*TABLES)-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // control and request registers
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [TSEL_W-1:0]     sel_ff, sel_in;
   logic [NAME_BITS-1:0]  key_ff, key_in;
   logic [PRIV_W-1:0]     priv_ff, priv_in;
   logic [UID_W-1:0]      uid_ff, uid_in;
   logic                  hit_ff, hit_in;
   logic                  hit_hi_ff, hit_hi_in;
   logic                  del_hit_ff, del_hit_in;
   logic [NAME_BITS-1:0]  best_name_ff, best_name_in;
   logic [PRIV_W-1:0]     best_priv_ff, best_priv_in;
   logic [UID_W-1:0]      best_uid_ff, best_uid_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [TSEL_W-1:0]     rsp_table_ff, rsp_table_in;
   logic [KEY_W-1:0]      rsp_name_ff, rsp_name_in;
   logic [PRIV_W-1:0]     rsp_priv_ff, rsp_priv_in;
   logic [UID_W-1:0]      rsp_uid_ff, rsp_uid_in;

   // per-table allocator and pointer
   logic [UID_W-1:0]      first_ff [TABLES];
   logic [UID_W-1:0]      first_in [TABLES];
   logic [UID_W-1:0]      last_ff  [TABLES];
   logic [UID_W-1:0]      last_in  [TABLES];
   logic [UID_W-1:0]      next_ff  [TABLES];
   logic [UID_W-1:0]      next_in  [TABLES];
   logic [IDX_W-1:0]      wp_ff    [TABLES];
   logic [IDX_W-1:0]      wp_in    [TABLES];

   // ring heads and controls
   logic [NAME_BITS-1:0]  head_name [TABLES];
   logic [PRIV_W-1:0]     head_priv [TABLES];
   logic [UID_W-1:0]      head_uid  [TABLES];
   logic                  name_eq   [TABLES];
   ring_ctrl_type         ring_ctrl [TABLES];

   logic                  req_fire;
   logic                  csr_fire;
   logic                  out_free;
   logic                  req_bad;
   logic                  bad_tab;
   logic                  insert;
   logic [IDX_W-1:0]      start_idx;
   logic                  k_hi;
   logic                  sel_match;
   logic                  rec_cmd;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_bad   = (int'(req_table_sel) >= TABLES) || (req_cmd > CMD_DELETE);
   assign bad_tab   = (int'(sel_ff) >= TABLES);
   assign insert    = (state_ff == ST_DONE) && out_free && !bad_tab &&
                      (cmd_ff == CMD_ADD) && !hit_ff;

   // search starts at the newest entry; slots at or past it come first in order
   assign start_idx = (wp_ff[sel_ff] == '0) ? LAST_IDX : (wp_ff[sel_ff] - 1'b1);
   assign k_hi      = (cnt_ff >= start_idx);
   assign sel_match = (cmd_ff == CMD_LOOKUP_UID) ? (head_uid[sel_ff] == uid_ff)
                                                 : name_eq[sel_ff];
   assign rec_cmd   = (cmd_ff == CMD_ADD) || (cmd_ff == CMD_LOOKUP_NAME) ||
                      (cmd_ff == CMD_LOOKUP_UID);

   // rotate every ring during the sweep; clear matches and insert new entries
   always_comb begin
      for (int u = 0; u < TABLES; u++) begin
         name_eq[u] = (head_name[u] == key_ff);
         ring_ctrl[u].shift = (state_ff == ST_SWEEP);
         ring_ctrl[u].clear_head = (state_ff == ST_SWEEP) && name_eq[u] &&
            (((cmd_ff == CMD_DELETE) && (int'(sel_ff) == u)) ||
             ((cmd_ff == CMD_ADD) && (int'(sel_ff) != u)));
         ring_ctrl[u].load = insert && (int'(sel_ff) == u);
      end
   end

   for (genvar g = 0; g < TABLES; g++) begin : g_table
      utrl_ring #(
         .ENTRIES  (ENTRIES),
         .NAME_BITS(NAME_BITS)
      ) u_ring (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ring_ctrl[g]),
         .load_idx (wp_ff[sel_ff]),
         .ld_name  (key_ff),
         .ld_priv  (priv_ff),
         .ld_uid   (next_ff[sel_ff]),
         .head_name(head_name[g]),
         .head_priv(head_priv[g]),
         .head_uid (head_uid[g])
      );
   end

   // sequence one item: latch, sweep, answer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      sel_in       = sel_ff;
      key_in       = key_ff;
      priv_in      = priv_ff;
      uid_in       = uid_ff;
      hit_in       = hit_ff;
      hit_hi_in    = hit_hi_ff;
      del_hit_in   = del_hit_ff;
      best_name_in = best_name_ff;
      best_priv_in = best_priv_ff;
      best_uid_in  = best_uid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_table_in  = rsp_table_ff;
      rsp_name_in   = rsp_name_ff;
      rsp_priv_in   = rsp_priv_ff;
      rsp_uid_in    = rsp_uid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_cmd;
               sel_in     = req_table_sel;
               key_in     = req_name_key[NAME_BITS-1:0];
               priv_in    = req_priv;
               uid_in     = req_uid;
               hit_in     = 1'b0;
               hit_hi_in  = 1'b0;
               del_hit_in = 1'b0;
               cnt_in     = '0;
               state_in   = req_bad ? ST_DONE : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // keep the first match in search order
            if (rec_cmd && sel_match && (!hit_ff || (k_hi && !hit_hi_ff))) begin
               hit_in       = 1'b1;
               hit_hi_in    = k_hi;
               best_name_in = head_name[sel_ff];
               best_priv_in = head_priv[sel_ff];
               best_uid_in  = head_uid[sel_ff];
            end
            if ((cmd_ff == CMD_DELETE) && name_eq[sel_ff]) begin
               del_hit_in = 1'b1;
            end
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_table_in  = sel_ff;
               rsp_name_in   = '0;
               rsp_priv_in   = '0;
               rsp_uid_in    = '0;
               if (bad_tab) begin
                  rsp_status_in = STATUS_BAD_TABLE;
                  rsp_table_in  = '0;
               end else begin
                  case (cmd_ff)
                     CMD_ADD:         rsp_status_in = STATUS_ADDED;
                     CMD_LOOKUP_NAME,
                     CMD_LOOKUP_UID:  rsp_status_in = hit_ff ? STATUS_RETRIEVED
                                                             : STATUS_NOT_FOUND;
                     CMD_DELETE:      rsp_status_in = del_hit_ff ? STATUS_DELETED
                                                                 : STATUS_NOT_FOUND;
                     default:         rsp_status_in = STATUS_BAD_CMD;
                  endcase
                  if (rec_cmd && hit_ff) begin
                     rsp_name_in = KEY_W'(best_name_ff);
                     rsp_priv_in = best_priv_ff;
                     rsp_uid_in  = best_uid_ff;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // uid registers, allocator and write pointer of each table
   always_comb begin
      for (int u = 0; u < TABLES; u++) begin
         first_in[u] = first_ff[u];
         last_in[u]  = last_ff[u];
         next_in[u]  = next_ff[u];
         wp_in[u]    = wp_ff[u];
         if (csr_fire && (int'(csr_index) == 2 * u)) begin
            first_in[u] = csr_data;
            next_in[u]  = csr_data;
         end
         if (csr_fire && (int'(csr_index) == 2 * u + 1)) begin
            last_in[u] = csr_data;
         end
         if (insert && (int'(sel_ff) == u)) begin
            next_in[u] = (next_ff[u] == last_ff[u]) ? first_ff[u] : (next_ff[u] + 1'b1);
            wp_in[u]   = (wp_ff[u] == LAST_IDX) ? '0 : (wp_ff[u] + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         hit_hi_ff    <= 1'b0;
         del_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int u = 0; u < TABLES; u++) begin
            first_ff[u] <= '0;
            last_ff[u]  <= '1;
            next_ff[u]  <= '0;
            wp_ff[u]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         hit_hi_ff    <= hit_hi_in;
         del_hit_ff   <= del_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int u = 0; u < TABLES; u++) begin
            first_ff[u] <= first_in[u];
            last_ff[u]  <= last_in[u];
            next_ff[u]  <= next_in[u];
            wp_ff[u]    <= wp_in[u];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sel_ff        <= sel_in;
      key_ff        <= key_in;
      priv_ff       <= priv_in;
      uid_ff        <= uid_in;
      best_name_ff  <= best_name_in;
      best_priv_ff  <= best_priv_in;
      best_uid_ff   <= best_uid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_table_ff  <= rsp_table_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_priv_ff   <= rsp_priv_in;
      rsp_uid_ff    <= rsp_uid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_table_out  = rsp_table_ff;
   assign rsp_found_name = rsp_name_ff;
   assign rsp_found_priv = rsp_priv_ff;
   assign rsp_found_uid  = rsp_uid_ff;

   // checks
   `UTRL_ASSERT_NEXT(a_sweep_ends, clock, reset,
      (state_ff == ST_SWEEP) && (cnt_ff == LAST_IDX), (state_ff == ST_DONE),
      "sweep did not end after the last slot")
   `UTRL_ASSERT_NEXT(a_sweep_starts, clock, reset,
      req_fire && !req_bad, (state_ff == ST_SWEEP) && (cnt_ff == '0),
      "sweep did not start at slot zero")
   `UTRL_ASSERT_SAME(a_insert_add, clock, reset,
      ring_ctrl[0].load || insert,
      (state_ff == ST_DONE) && (cmd_ff == CMD_ADD) && !hit_ff && out_free,
      "insert outside a fresh add")
   `UTRL_ASSERT_NEXT(a_done_waits, clock, reset,
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, (state_ff == ST_DONE),
      "result written over a waiting item")

endmodule

// ===== bench/tb_user_table_ring_lookup.sv =====
// Self-checking testbench for the user table ring lookup block.
module tb_user_table_ring_lookup
   import utrl_pkg::*;
();

   localparam int CLK_PERIOD      = 10;
   localparam int NUM_SLOTS       = 16;
   localparam int NUM_TABLES      = 3;
   localparam int CSR_IDX_W       = $clog2(2 * NUM_TABLES);
   localparam int KEY_POOL        = 24;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int LONG_HOLD       = 400;
   localparam int SETTLE_CYCLES   = NUM_SLOTS + 4;
   localparam int TIMEOUT_CYCLES  = 1_000_000;

   // register map: two bounds per table
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UID_T0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_UID_T0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UID_T1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_UID_T1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UID_T2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_UID_T2  = 3'd5;

   localparam bit BOUND_FIRST = 1'b0;
   localparam bit BOUND_LAST  = 1'b1;

   // commands with no meaning, and the table number past the last table
   localparam logic [CMD_W-1:0]  CMD_FIRST_INVALID = 3'd4;
   localparam logic [CMD_W-1:0]  CMD_LAST_INVALID  = 3'd7;
   localparam logic [TSEL_W-1:0] TSEL_OUT_OF_RANGE = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TSEL_W-1:0] tsel;
      logic [KEY_W-1:0]  key;
      logic [PRIV_W-1:0] priv;
      logic [UID_W-1:0]  uid;
   } lookup_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TSEL_W-1:0]   tbl;
      logic [KEY_W-1:0]    name;
      logic [PRIV_W-1:0]   priv;
      logic [UID_W-1:0]    uid;
   } lookup_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [TSEL_W-1:0]     req_table_sel = '0;
   logic [KEY_W-1:0]      req_name_key = '0;
   logic [PRIV_W-1:0]     req_priv = '0;
   logic [UID_W-1:0]      req_uid = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [TSEL_W-1:0]     rsp_table_out;
   logic [KEY_W-1:0]      rsp_found_name;
   logic [PRIV_W-1:0]     rsp_found_priv;
   logic [UID_W-1:0]      rsp_found_uid;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow copy of the tables and uid allocators
   logic [KEY_W-1:0]  tbl_name [NUM_TABLES][NUM_SLOTS];
   logic [PRIV_W-1:0] tbl_priv [NUM_TABLES][NUM_SLOTS];
   logic [UID_W-1:0]  tbl_uid  [NUM_TABLES][NUM_SLOTS];
   int                wr_ptr   [NUM_TABLES];
   logic [UID_W-1:0]  uid_next [NUM_TABLES];
   logic [UID_W-1:0]  uid_first[NUM_TABLES];
   logic [UID_W-1:0]  uid_last [NUM_TABLES];

   lookup_req_type reqs_to_send[$];
   lookup_rsp_type results_due[$];
   logic [KEY_W-1:0] key_pool[KEY_POOL];

   int  reqs_queued = 0;
   int  reqs_accepted = 0;
   int  mismatch_count = 0;
   bit  req_taken = 1'b0;
   bit  tx_idle_en = 1'b1;
   bit  rx_idle_en = 1'b1;
   int  tx_gap_left = 0;
   int  rx_stall_left = 0;
   int  rx_block_left = 0;

   user_table_ring_lookup i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_table_sel  (req_table_sel),
      .req_name_key   (req_name_key),
      .req_priv       (req_priv),
      .req_uid        (req_uid),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_table_out  (rsp_table_out),
      .rsp_found_name (rsp_found_name),
      .rsp_found_priv (rsp_found_priv),
      .rsp_found_uid  (rsp_found_uid),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      else if (r < 95) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // Slot visited at step k: newest entry first, then onward with wrap.
   function automatic int search_slot(int t, int k);
      int newest;
      newest = (wr_ptr[t] == 0) ? NUM_SLOTS - 1 : wr_ptr[t] - 1;
      return (newest + k) % NUM_SLOTS;
   endfunction

   function automatic int find_key(int t, logic [KEY_W-1:0] key);
      int slot;
      int hit;
      hit = -1;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot = search_slot(t, k);
         if (hit < 0 && tbl_name[t][slot] == key) hit = slot;
      end
      return hit;
   endfunction

   // Clear every entry of table t holding the key; tell whether any was hit.
   function automatic bit purge_key(int t, logic [KEY_W-1:0] key);
      bit any;
      any = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (tbl_name[t][s] == key) begin
            tbl_name[t][s] = '0;
            tbl_priv[t][s] = '0;
            tbl_uid[t][s]  = '0;
            any = 1'b1;
         end
      end
      return any;
   endfunction

   // Apply one request to the shadow tables and work out its result.
   task automatic predict_lookup(input lookup_req_type r, output lookup_rsp_type e);
      int t;
      int hit;
      int slot;
      e = '0;
      hit = -1;
      t = r.tsel;
      if (t >= NUM_TABLES) begin
         e.status = STATUS_BAD_TABLE;
      end else begin
         e.tbl = r.tsel;
         case (r.cmd)
            CMD_ADD: begin
               hit = find_key(t, r.key);
               if (hit < 0) begin
                  slot = wr_ptr[t];
                  tbl_name[t][slot] = r.key;
                  tbl_priv[t][slot] = r.priv;
                  tbl_uid[t][slot]  = uid_next[t];
                  uid_next[t] = (uid_next[t] == uid_last[t]) ? uid_first[t]
                                                             : uid_next[t] + 32'd1;
                  wr_ptr[t] = (slot + 1) % NUM_SLOTS;
               end
               e.status = STATUS_ADDED;
               for (int u = 0; u < NUM_TABLES; u++)
                  if (u != t) void'(purge_key(u, r.key));
            end
            CMD_LOOKUP_NAME: begin
               hit = find_key(t, r.key);
               e.status = (hit >= 0) ? STATUS_RETRIEVED : STATUS_NOT_FOUND;
            end
            CMD_LOOKUP_UID: begin
               for (int k = 0; k < NUM_SLOTS; k++) begin
                  slot = search_slot(t, k);
                  if (hit < 0 && tbl_uid[t][slot] == r.uid) hit = slot;
               end
               e.status = (hit >= 0) ? STATUS_RETRIEVED : STATUS_NOT_FOUND;
            end
            CMD_DELETE: begin
               e.status = purge_key(t, r.key) ? STATUS_DELETED : STATUS_NOT_FOUND;
            end
            default: begin
               e.status = STATUS_BAD_CMD;
            end
         endcase
         if (hit >= 0) begin
            e.name = tbl_name[t][hit];
            e.priv = tbl_priv[t][hit];
            e.uid  = tbl_uid[t][hit];
         end
      end
   endtask

   task automatic report_mismatch(string what, logic [KEY_W-1:0] got,
                                  logic [KEY_W-1:0] want);
      mismatch_count++;
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic push_req(logic [CMD_W-1:0] cmd, logic [TSEL_W-1:0] tsel,
                           logic [KEY_W-1:0] key, logic [PRIV_W-1:0] priv,
                           logic [UID_W-1:0] uid);
      lookup_req_type item;
      item.cmd  = cmd;
      item.tsel = tsel;
      item.key  = key;
      item.priv = priv;
      item.uid  = uid;
      reqs_to_send.push_back(item);
      reqs_queued++;
   endtask

   // Wait until every queued item is taken and every result has come back.
   task automatic wait_drained();
      @(negedge clock);
      while (reqs_accepted != reqs_queued || results_due.size() != 0)
         @(negedge clock);
   endtask

   // Write one uid bound of table t and mirror it in the shadow copy.
   task automatic write_uid_bound(int t, bit which, logic [UID_W-1:0] value);
      logic [CSR_IDX_W-1:0] idx;
      case (t)
         0:       idx = (which == BOUND_LAST) ? REG_LAST_UID_T0 : REG_FIRST_UID_T0;
         1:       idx = (which == BOUND_LAST) ? REG_LAST_UID_T1 : REG_FIRST_UID_T1;
         default: idx = (which == BOUND_LAST) ? REG_LAST_UID_T2 : REG_FIRST_UID_T2;
      endcase
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (which == BOUND_LAST) begin
         uid_last[t] = value;
      end else begin
         uid_first[t] = value;
         uid_next[t]  = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drive items from the pending queue, with random gaps between them.
   always @(negedge clock) begin : req_driver
      lookup_req_type item;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (tx_gap_left > 0) begin
            tx_gap_left--;
            req_valid <= 1'b0;
         end else if (reqs_to_send.size() > 0) begin
            item = reqs_to_send.pop_front();
            req_cmd       <= item.cmd;
            req_table_sel <= item.tsel;
            req_name_key  <= item.key;
            req_priv      <= item.priv;
            req_uid       <= item.uid;
            req_valid     <= 1'b1;
            if (tx_idle_en) tx_gap_left = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side: a long hold-off on request, else random stalls.
   always @(negedge clock) begin : rsp_sink
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_block_left > 0) begin
         rx_block_left--;
         rsp_ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rx_idle_en) rx_stall_left = idle_len();
      end
   end

   // Check each result against the oldest expectation, then predict new items.
   always @(posedge clock) begin : monitor
      lookup_rsp_type want;
      lookup_req_type seen;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               report_mismatch("result with nothing pending", KEY_W'(rsp_status), '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", KEY_W'(rsp_status), KEY_W'(want.status));
               if (rsp_table_out !== want.tbl)
                  report_mismatch("table_out", KEY_W'(rsp_table_out), KEY_W'(want.tbl));
               if (rsp_found_name !== want.name)
                  report_mismatch("found_name", rsp_found_name, want.name);
               if (rsp_found_priv !== want.priv)
                  report_mismatch("found_priv", KEY_W'(rsp_found_priv), KEY_W'(want.priv));
               if (rsp_found_uid !== want.uid)
                  report_mismatch("found_uid", KEY_W'(rsp_found_uid), KEY_W'(want.uid));
            end
         end
         if (req_valid && req_ready) begin
            seen.cmd  = req_cmd;
            seen.tsel = req_table_sel;
            seen.key  = req_name_key;
            seen.priv = req_priv;
            seen.uid  = req_uid;
            predict_lookup(seen, want);
            results_due.push_back(want);
            reqs_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // Stimulus: directed items, then phases of random items under new uid bounds.
   initial begin : stimulus
      lookup_req_type item;
      logic [UID_W-1:0] lo;
      logic [UID_W-1:0] hi;
      int r;
      for (int t = 0; t < NUM_TABLES; t++) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            tbl_name[t][s] = '0;
            tbl_priv[t][s] = '0;
            tbl_uid[t][s]  = '0;
         end
         wr_ptr[t]    = 0;
         uid_first[t] = '0;
         uid_last[t]  = '1;
         uid_next[t]  = '0;
      end
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty slots match name zero and uid zero
      push_req(CMD_LOOKUP_NAME, 2'd0, '0, '0, '0);
      push_req(CMD_LOOKUP_UID, 2'd1, '0, '0, '0);
      // fresh add, then add of a present name
      push_req(CMD_ADD, 2'd0, '1, '1, '1);
      push_req(CMD_ADD, 2'd0, '1, '0, '0);
      push_req(CMD_LOOKUP_UID, 2'd0, '0, '0, '1);
      // add to another table moves the name away from table zero
      push_req(CMD_ADD, 2'd1, '1, 8'h5A, '0);
      push_req(CMD_LOOKUP_NAME, 2'd0, '1, '0, '0);
      // delete of empty slots, delete of an absent name
      push_req(CMD_DELETE, 2'd2, '0, '0, '0);
      push_req(CMD_DELETE, 2'd2, '1, '0, '0);
      push_req(CMD_ADD, 2'd2, '0, 8'h11, '0);
      push_req(CMD_DELETE, 2'd1, '1, '0, '0);
      // commands with no meaning
      push_req(CMD_FIRST_INVALID, 2'd0, '1, '1, '1);
      push_req(CMD_FIRST_INVALID + 3'd1, 2'd1, '0, '0, '0);
      push_req(CMD_LAST_INVALID - 3'd1, 2'd2, '0, '0, '0);
      push_req(CMD_LAST_INVALID, 2'd0, '0, '0, '0);
      // table out of range wins over everything
      push_req(CMD_ADD, TSEL_OUT_OF_RANGE, '1, '1, '1);
      push_req(CMD_LOOKUP_NAME, TSEL_OUT_OF_RANGE, '0, '0, '0);
      push_req(CMD_LOOKUP_UID, TSEL_OUT_OF_RANGE, '0, '0, '0);
      push_req(CMD_DELETE, TSEL_OUT_OF_RANGE, '0, '0, '0);
      push_req(CMD_LAST_INVALID, TSEL_OUT_OF_RANGE, '0, '0, '0);
      push_req(CMD_ADD, 2'd1, 64'h0123_4567_89AB_CDEF, '1, '0);
      push_req(CMD_LOOKUP_UID, 2'd1, '0, '0, 32'd1);
      push_req(CMD_LOOKUP_NAME, 2'd1, 64'h0123_4567_89AB_CDEF, '0, '0);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // let the block go idle before touching the bounds
         wait_drained();
         repeat (SETTLE_CYCLES) @(negedge clock);
         tx_idle_en = (phase % 3) != 2;
         rx_idle_en = (phase % 3) != 1;
         for (int t = 0; t < NUM_TABLES; t++) begin
            case ((phase * NUM_TABLES + t) % 7)
               0: begin lo = '0; hi = '1; end
               1: begin lo = $urandom; hi = lo; end
               2: begin lo = $urandom; hi = lo + 32'd3; end
               3: begin lo = 32'hFFFF_FFFE; hi = 32'h0000_0001; end
               4: begin lo = '0; hi = '0; end
               5: begin lo = $urandom; hi = $urandom; end
               default: begin lo = 32'hFFFF_FFF0; hi = '1; end
            endcase
            if ($urandom_range(0, 1)) begin
               write_uid_bound(t, BOUND_LAST, hi);
               write_uid_bound(t, BOUND_FIRST, lo);
            end else begin
               write_uid_bound(t, BOUND_FIRST, lo);
               write_uid_bound(t, BOUND_LAST, hi);
            end
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            while (reqs_to_send.size() >= 2) @(negedge clock);
            // hold off the result side while items keep coming
            if (phase == 2 && n == 40) rx_block_left = LONG_HOLD;
            // pause the sender until everything is back
            if (phase == 4 && n == 75) wait_drained();

            r = $urandom_range(0, 99);
            if (r < 36) item.cmd = CMD_ADD;
            else if (r < 60) item.cmd = CMD_LOOKUP_NAME;
            else if (r < 80) item.cmd = CMD_LOOKUP_UID;
            else if (r < 92) item.cmd = CMD_DELETE;
            else item.cmd = CMD_W'($urandom_range(CMD_FIRST_INVALID, CMD_LAST_INVALID));

            item.tsel = ($urandom_range(0, 99) < 95) ?
                        TSEL_W'($urandom_range(0, NUM_TABLES - 1)) : TSEL_OUT_OF_RANGE;
            r = $urandom_range(0, 99);
            if (r < 84) item.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            else if (r < 88) item.key = '0;
            else if (r < 92) item.key = '1;
            else item.key = {$urandom, $urandom};
            item.priv = PRIV_W'($urandom);

            // aim uid lookups mostly at uids held in the table
            r = $urandom_range(0, 99);
            item.uid = $urandom;
            if (item.cmd == CMD_LOOKUP_UID && item.tsel < NUM_TABLES) begin
               if (r < 65) item.uid = tbl_uid[item.tsel][$urandom_range(0, NUM_SLOTS - 1)];
               else if (r < 75) item.uid = '0;
               else if (r < 80) item.uid = uid_next[item.tsel];
            end
            reqs_to_send.push_back(item);
            reqs_queued++;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
